>>> sv/fsft_pkg.sv
// Shared types and constants for the fixed-timestep frame timer.
package fsft_pkg;

  localparam int unsigned DIV_W  = 48;
  localparam int unsigned DVSR_W = 24;
  localparam int unsigned CNT_W  = 6;

  localparam logic [1:0] FUNC_BEGIN = 2'd0;
  localparam logic [1:0] FUNC_FRAME = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  localparam logic [7:0] REG_STEP   = 8'd0;
  localparam logic [7:0] REG_MAXD   = 8'd1;
  localparam logic [7:0] REG_SCALE  = 8'd2;
  localparam logic [7:0] REG_PAUSED = 8'd3;

  localparam logic [19:0] DEFAULT_STEP  = 20'd16667;
  localparam logic [23:0] DEFAULT_MAXD  = 24'd250000;
  localparam logic [15:0] DEFAULT_SCALE = 16'd256;
  localparam logic [27:0] RATE_NUM     = 28'd256000000;

  // Reciprocal of ten scaled by 2^35, exact for any 32-bit dividend.
  localparam logic [31:0] RECIP_TEN = 32'hCCCCCCCD;

  localparam logic [1:0] OP_INST   = 2'd0;
  localparam logic [1:0] OP_SMOOTH = 2'd1;
  localparam logic [1:0] OP_ALPHA  = 2'd2;

  typedef struct packed {
    logic       latch;
    logic       exec;
    logic       mul;
    logic       upd;
    logic       div_start;
    logic       sm_mul;
    logic       cap;
    logic [1:0] op;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       paused;
    logic       d_zero;
    logic       div_done;
  } status_t;

endpackage

>>> sv/fixed_timestep_frame_timer.sv
// Top level of the fixed-timestep frame timer.
// The input channel takes one item with a function code and a raw frame time
// in microseconds: begin frame, frame update or fixed-step query. Each item
// gives exactly one result item on the output channel with the current delta,
// accumulator, interpolation fraction, smoothed frame rate and counters.
// The configuration channel is always ready and writes the step length, the
// delta clip, the time scale and the pause flag by register index.
// Items are handled one at a time. The bit-serial divider gives the instant
// rate and the interpolation fraction, while the divide by ten of the rate
// filter is a reciprocal multiplication. The input is ready again in the
// cycle after the result is loaded, so a new item is taken only after the
// result of the last one is loaded. The next item is taken while a result
// waits in the output register; if the receiver stalls, the block holds the
// following result until that register is free. Reset restores the default
// configuration and clears all timing state, with no result pending.
module fixed_timestep_frame_timer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [23:0] raw_delta_us_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [23:0] delta_us_o,
  output logic        fixed_due_o,
  output logic [31:0] accum_us_o,
  output logic [23:0] alpha_q16_o,
  output logic [27:0] fps_q8_o,
  output logic [47:0] frames_o,
  output logic [55:0] total_us_o,
  output logic [23:0] min_delta_seen_o,
  output logic [23:0] max_delta_seen_o,
  output logic [15:0] steps_this_frame_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  fsft_pkg::cmd_t    cmd;
  fsft_pkg::status_t sts;

  assign cfg_ready_o = 1'b1;

  fsft_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fsft_dpath u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .func_i             (func_i),
    .raw_delta_us_i     (raw_delta_us_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .delta_us_o         (delta_us_o),
    .fixed_due_o        (fixed_due_o),
    .accum_us_o         (accum_us_o),
    .alpha_q16_o        (alpha_q16_o),
    .fps_q8_o           (fps_q8_o),
    .frames_o           (frames_o),
    .total_us_o         (total_us_o),
    .min_delta_seen_o   (min_delta_seen_o),
    .max_delta_seen_o   (max_delta_seen_o),
    .steps_this_frame_o (steps_this_frame_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken again right after an item");

  a_due_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fixed_due_o) |-> (steps_this_frame_o != '0))
    else $error("drained step not counted");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && min_delta_seen_o != '0) |-> (min_delta_seen_o <= max_delta_seen_o))
    else $error("minimum delta above maximum delta");

endmodule

>>> sv/fsft_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module fsft_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [fsft_pkg::DIV_W-1:0]     dividend_i,
  input  logic [fsft_pkg::DVSR_W-1:0]    divisor_i,
  output logic [fsft_pkg::DIV_W-1:0]     quot_o,
  output logic                           done_o
);

  logic [fsft_pkg::DIV_W-1:0]  q_q, q_d;
  logic [fsft_pkg::DVSR_W-1:0] r_q, r_d, dv_q, dv_d;
  logic [fsft_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                        busy_q, busy_d, done_q, done_d;
  logic [fsft_pkg::DVSR_W:0]   trial;
  logic [fsft_pkg::DVSR_W:0]   diff;

  assign trial = {r_q, q_q[fsft_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, dv_q};

  always_comb begin
    q_d    = q_q;
    r_d    = r_q;
    dv_d   = dv_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      q_d    = dividend_i;
      r_d    = '0;
      dv_d   = divisor_i;
      cnt_d  = fsft_pkg::CNT_W'(fsft_pkg::DIV_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dv_q}) begin
        r_d = diff[fsft_pkg::DVSR_W-1:0];
        q_d = {q_q[fsft_pkg::DIV_W-2:0], 1'b1};
      end else begin
        r_d = trial[fsft_pkg::DVSR_W-1:0];
        q_d = {q_q[fsft_pkg::DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q  <= q_d;
    r_q  <= r_d;
    dv_q <= dv_d;
  end

  assign quot_o = q_q;
  assign done_o = done_q;

endmodule

>>> sv/fsft_ctrl.sv
// Controller state machine that sequences one item through the datapath.
module fsft_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  fsft_pkg::status_t sts_i,
  output fsft_pkg::cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EXEC   = 4'd1;
  localparam logic [3:0] S_MUL    = 4'd2;
  localparam logic [3:0] S_UPD    = 4'd3;
  localparam logic [3:0] S_INST   = 4'd4;
  localparam logic [3:0] S_WINST  = 4'd5;
  localparam logic [3:0] S_SMOOTH = 4'd6;
  localparam logic [3:0] S_WSM    = 4'd7;
  localparam logic [3:0] S_ALPHA  = 4'd8;
  localparam logic [3:0] S_WAL    = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  logic [3:0] state_q, state_d;
  logic       ov_q, ov_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.func == fsft_pkg::FUNC_FRAME && !sts_i.paused) state_d = S_MUL;
        else state_d = S_ALPHA;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_UPD;
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = S_INST;
      end
      S_INST: begin
        if (sts_i.d_zero) begin
          state_d = S_SMOOTH;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.op        = fsft_pkg::OP_INST;
          state_d         = S_WINST;
        end
      end
      S_WINST: begin
        cmd_o.op = fsft_pkg::OP_INST;
        if (sts_i.div_done) begin
          cmd_o.cap = 1'b1;
          state_d   = S_SMOOTH;
        end
      end
      S_SMOOTH: begin
        cmd_o.sm_mul = 1'b1;
        state_d      = S_WSM;
      end
      S_WSM: begin
        cmd_o.op  = fsft_pkg::OP_SMOOTH;
        cmd_o.cap = 1'b1;
        state_d   = S_ALPHA;
      end
      S_ALPHA: begin
        cmd_o.div_start = 1'b1;
        cmd_o.op        = fsft_pkg::OP_ALPHA;
        state_d         = S_WAL;
      end
      S_WAL: begin
        cmd_o.op = fsft_pkg::OP_ALPHA;
        if (sts_i.div_done) begin
          cmd_o.cap = 1'b1;
          state_d   = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    if (cmd_o.load_out) ov_d = 1'b1;
    else if (out_ready_i) ov_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

endmodule

>>> sv/fsft_dpath.sv
// Datapath with configuration, timing state, divider and output register.
module fsft_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [7:0]        cfg_index_i,
  input  logic [23:0]       cfg_data_i,
  input  logic [1:0]        func_i,
  input  logic [23:0]       raw_delta_us_i,
  input  fsft_pkg::cmd_t    cmd_i,
  output fsft_pkg::status_t sts_o,
  output logic [23:0]       delta_us_o,
  output logic              fixed_due_o,
  output logic [31:0]       accum_us_o,
  output logic [23:0]       alpha_q16_o,
  output logic [27:0]       fps_q8_o,
  output logic [47:0]       frames_o,
  output logic [55:0]       total_us_o,
  output logic [23:0]       min_delta_seen_o,
  output logic [23:0]       max_delta_seen_o,
  output logic [15:0]       steps_this_frame_o
);

  logic [19:0] step_q;
  logic [23:0] maxd_q;
  logic [15:0] scale_q;
  logic        paused_q;
  logic [1:0]  func_q;
  logic [23:0] raw_q;
  logic [39:0] prod_q;
  logic [31:0] accum_q;
  logic [55:0] total_q;
  logic [47:0] frames_q;
  logic [23:0] min_q, max_q, last_q, alpha_q;
  logic [27:0] smooth_q, inst_q;
  logic [15:0] steps_q;
  logic        due_q;
  logic [63:0] sm_prod_q;

  logic [31:0] scaled;
  logic [23:0] dclip;
  logic [32:0] acc_sum;
  logic [56:0] tot_sum;
  logic [31:0] sm_num;
  logic [fsft_pkg::DIV_W-1:0]  dividend, quot;
  logic [fsft_pkg::DVSR_W-1:0] divisor;
  logic        div_done;

  assign scaled  = prod_q[39:8];
  assign dclip   = (scaled > {8'b0, maxd_q}) ? maxd_q : scaled[23:0];
  assign acc_sum = {1'b0, accum_q} + {9'b0, dclip};
  assign tot_sum = {1'b0, total_q} + {33'b0, dclip};
  assign sm_num  = {1'b0, smooth_q, 3'b0} + {4'b0, smooth_q} + {4'b0, inst_q} + 32'd5;

  always_comb begin
    case (cmd_i.op)
      fsft_pkg::OP_INST: begin
        dividend = {20'b0, fsft_pkg::RATE_NUM};
        divisor  = last_q;
      end
      default: begin
        dividend = {accum_q, 16'b0};
        divisor  = {4'b0, step_q};
      end
    endcase
  end

  fsft_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  assign sts_o.func     = func_q;
  assign sts_o.paused   = paused_q;
  assign sts_o.d_zero   = (last_q == '0);
  assign sts_o.div_done = div_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= fsft_pkg::DEFAULT_STEP;
      maxd_q   <= fsft_pkg::DEFAULT_MAXD;
      scale_q  <= fsft_pkg::DEFAULT_SCALE;
      paused_q <= 1'b0;
      accum_q  <= '0;
      total_q  <= '0;
      frames_q <= '0;
      min_q    <= '1;
      max_q    <= '0;
      smooth_q <= '0;
      last_q   <= '0;
      steps_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          fsft_pkg::REG_STEP:
            step_q <= (cfg_data_i[19:0] == '0) ? fsft_pkg::DEFAULT_STEP : cfg_data_i[19:0];
          fsft_pkg::REG_MAXD:
            maxd_q <= (cfg_data_i == '0) ? fsft_pkg::DEFAULT_MAXD : cfg_data_i;
          fsft_pkg::REG_SCALE:  scale_q  <= cfg_data_i[15:0];
          fsft_pkg::REG_PAUSED: paused_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.exec) begin
        case (func_q)
          fsft_pkg::FUNC_BEGIN: steps_q <= '0;
          fsft_pkg::FUNC_FRAME: if (paused_q) last_q <= '0;
          fsft_pkg::FUNC_QUERY: begin
            if (accum_q >= {12'b0, step_q}) begin
              accum_q <= accum_q - {12'b0, step_q};
              if (steps_q != '1) steps_q <= steps_q + 16'd1;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.upd) begin
        last_q  <= dclip;
        accum_q <= acc_sum[32] ? '1 : acc_sum[31:0];
        total_q <= tot_sum[56] ? '1 : tot_sum[55:0];
        if (frames_q != '1) frames_q <= frames_q + 48'd1;
        if (raw_q != '0) begin
          if (raw_q < min_q) min_q <= raw_q;
          if (raw_q > max_q) max_q <= raw_q;
        end
      end
      if (cmd_i.cap && cmd_i.op == fsft_pkg::OP_SMOOTH) smooth_q <= sm_prod_q[62:35];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q <= func_i;
      raw_q  <= raw_delta_us_i;
    end
    if (cmd_i.exec) begin
      due_q <= (func_q == fsft_pkg::FUNC_QUERY) && (accum_q >= {12'b0, step_q});
    end
    if (cmd_i.mul) prod_q <= raw_q * scale_q;
    if (cmd_i.sm_mul) sm_prod_q <= sm_num * fsft_pkg::RECIP_TEN;
    if (cmd_i.upd) inst_q <= '0;
    if (cmd_i.cap && cmd_i.op == fsft_pkg::OP_INST) inst_q <= quot[27:0];
    if (cmd_i.cap && cmd_i.op == fsft_pkg::OP_ALPHA) begin
      alpha_q <= (quot[47:24] != '0) ? '1 : quot[23:0];
    end
    if (cmd_i.load_out) begin
      delta_us_o         <= last_q;
      fixed_due_o        <= due_q;
      accum_us_o         <= accum_q;
      alpha_q16_o        <= alpha_q;
      fps_q8_o           <= smooth_q;
      frames_o           <= frames_q;
      total_us_o         <= total_q;
      min_delta_seen_o   <= (min_q == '1) ? '0 : min_q;
      max_delta_seen_o   <= max_q;
      steps_this_frame_o <= steps_q;
    end
  end

endmodule

>>> test/fixed_timestep_frame_timer_test.sv
// Self-checking testbench for the fixed-timestep frame timer.
module fixed_timestep_frame_timer_test;

  typedef struct packed {
    logic [23:0] delta;
    logic        due;
    logic [31:0] accum;
    logic [23:0] alpha;
    logic [27:0] fps;
    logic [47:0] frames;
    logic [55:0] total;
    logic [23:0] dmin;
    logic [23:0] dmax;
    logic [15:0] steps;
  } timer_result_t;

  class timer_scoreboard;
    logic [19:0] step_len;
    logic [23:0] clip;
    logic [15:0] scale;
    logic        hold;
    logic [31:0] acc;
    logic [55:0] total;
    logic [47:0] frames;
    logic [23:0] dmin;
    logic [23:0] dmax;
    logic [27:0] rate;
    logic [23:0] last;
    logic [15:0] steps;
    timer_result_t pending[$];
    int errors;

    function new();
      step_len = fsft_pkg::DEFAULT_STEP;
      clip = fsft_pkg::DEFAULT_MAXD;
      scale = fsft_pkg::DEFAULT_SCALE;
      hold = 1'b0;
      acc = '0;
      total = '0;
      frames = '0;
      dmin = '1;
      dmax = '0;
      rate = '0;
      last = '0;
      steps = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [23:0] val);
      case (idx)
        fsft_pkg::REG_STEP:
          step_len = (val[19:0] == '0) ? fsft_pkg::DEFAULT_STEP : val[19:0];
        fsft_pkg::REG_MAXD:   clip = (val == '0) ? fsft_pkg::DEFAULT_MAXD : val;
        fsft_pkg::REG_SCALE:  scale = val[15:0];
        fsft_pkg::REG_PAUSED: hold = val[0];
        default: ;
      endcase
    endfunction

    function void note_item(logic [1:0] func, logic [23:0] raw);
      logic [63:0] d, inst, a;
      timer_result_t r;
      logic due;
      due = 1'b0;
      if (func == fsft_pkg::FUNC_BEGIN) begin
        steps = '0;
      end else if (func == fsft_pkg::FUNC_FRAME) begin
        if (hold) begin
          last = '0;
        end else begin
          d = (64'(raw) * 64'(scale)) >> 8;
          if (d > 64'(clip)) d = 64'(clip);
          last = d[23:0];
          acc = (64'(acc) + 64'(last) > 64'hFFFFFFFF) ? '1 : acc + 32'(last);
          total = (64'(total) + 64'(last) > 64'hFFFFFFFFFFFFFF) ? '1 : total + 56'(last);
          if (frames != '1) frames = frames + 48'd1;
          if (raw != '0) begin
            if (raw < dmin) dmin = raw;
            if (raw > dmax) dmax = raw;
          end
          inst = (last != '0) ? 64'd256000000 / 64'(last) : 64'd0;
          rate = 28'((64'd9 * 64'(rate) + inst + 64'd5) / 64'd10);
        end
      end else if (func == fsft_pkg::FUNC_QUERY) begin
        if (acc >= 32'(step_len)) begin
          acc = acc - 32'(step_len);
          if (steps != '1) steps = steps + 16'd1;
          due = 1'b1;
        end
      end
      a = (64'(acc) << 16) / 64'(step_len);
      if (a > 64'hFFFFFF) a = 64'hFFFFFF;
      r.delta = last;
      r.due = due;
      r.accum = acc;
      r.alpha = a[23:0];
      r.fps = rate;
      r.frames = frames;
      r.total = total;
      r.dmin = (dmin == '1) ? '0 : dmin;
      r.dmax = dmax;
      r.steps = steps;
      pending.push_back(r);
    endfunction

    function void check_result(timer_result_t got);
      timer_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result", $time);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.delta !== e.delta) report("delta_us", e.delta, got.delta);
      if (got.due !== e.due) report("fixed_due", e.due, got.due);
      if (got.accum !== e.accum) report("accum_us", e.accum, got.accum);
      if (got.alpha !== e.alpha) report("alpha_q16", e.alpha, got.alpha);
      if (got.fps !== e.fps) report("fps_q8", e.fps, got.fps);
      if (got.frames !== e.frames) report("frames", e.frames, got.frames);
      if (got.total !== e.total) report("total_us", e.total, got.total);
      if (got.dmin !== e.dmin) report("min_delta_seen", e.dmin, got.dmin);
      if (got.dmax !== e.dmax) report("max_delta_seen", e.dmax, got.dmax);
      if (got.steps !== e.steps) report("steps_this_frame", e.steps, got.steps);
    endfunction

    function void report(string name, logic [63:0] e, logic [63:0] g);
      $display("%0t: %s expected %0d actual %0d", $time, name, e, g);
      errors++;
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_ready_o;
  logic [1:0] func_i = 0;
  logic [23:0] raw_delta_us_i = 0;
  logic out_valid_o;
  logic out_ready_i = 0;
  timer_result_t got;
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  logic [7:0] cfg_index_i = 0;
  logic [23:0] cfg_data_i = 0;

  timer_scoreboard sb = new();
  bit quiet = 0;
  int idle_cycles = 0;

  fixed_timestep_frame_timer dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i, .raw_delta_us_i,
    .out_valid_o, .out_ready_i,
    .delta_us_o(got.delta), .fixed_due_o(got.due), .accum_us_o(got.accum),
    .alpha_q16_o(got.alpha), .fps_q8_o(got.fps), .frames_o(got.frames),
    .total_us_o(got.total), .min_delta_seen_o(got.dmin),
    .max_delta_seen_o(got.dmax), .steps_this_frame_o(got.steps),
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(got);
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > 20000) begin
      $display("fixed_timestep_frame_timer_test: FAIL");
      $finish;
    end
  end

  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 12);
        out_ready_i <= 0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1;
    end
  end

  // Valid stays high from one item to the next unless an idle gap is drawn or a register write comes between.
  task automatic send_item(logic [1:0] func, logic [23:0] raw);
    int n;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 12);
      in_valid_i <= 0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1;
    func_i <= func;
    raw_delta_us_i <= raw;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(func, raw);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [23:0] val);
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    cfg_valid_i <= 0;
  endtask

  task automatic random_item();
    logic [1:0] f;
    logic [23:0] raw;
    f = $urandom_range(0, 9) < 5 ? fsft_pkg::FUNC_FRAME : 2'($urandom_range(0, 3));
    case ($urandom_range(0, 7))
      0: raw = 24'($urandom);
      1: raw = '0;
      2: raw = 24'($urandom_range(0, 10000000));
      default: raw = 24'($urandom_range(1, 60000));
    endcase
    send_item(f, raw);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_item(fsft_pkg::FUNC_QUERY, 24'd0);
    send_item(fsft_pkg::FUNC_FRAME, 24'd0);
    send_item(fsft_pkg::FUNC_FRAME, 24'hFFFFFF);
    send_item(fsft_pkg::FUNC_FRAME, 24'd10000000);
    send_item(fsft_pkg::FUNC_FRAME, 24'd1);
    send_item(fsft_pkg::FUNC_FRAME, 24'd16667);
    send_item(fsft_pkg::FUNC_QUERY, 24'hFFFFFF);
    send_item(fsft_pkg::FUNC_QUERY, 24'd0);
    send_item(fsft_pkg::FUNC_BEGIN, 24'hFFFFFF);
    send_item(2'd3, 24'h5A5A5A);
    write_reg(fsft_pkg::REG_PAUSED, 24'd1);
    send_item(fsft_pkg::FUNC_FRAME, 24'd5000);
    send_item(fsft_pkg::FUNC_QUERY, 24'd0);
    write_reg(fsft_pkg::REG_PAUSED, 24'd0);
    write_reg(fsft_pkg::REG_STEP, 24'd0);
    write_reg(fsft_pkg::REG_MAXD, 24'd0);
    write_reg(fsft_pkg::REG_SCALE, 24'hFFFF);
    send_item(fsft_pkg::FUNC_FRAME, 24'hFFFFFF);
    write_reg(fsft_pkg::REG_STEP, 24'd1);
    write_reg(fsft_pkg::REG_MAXD, 24'hFFFFFF);
    send_item(fsft_pkg::FUNC_FRAME, 24'hFFFFFF);
    send_item(fsft_pkg::FUNC_QUERY, 24'd0);
    write_reg(fsft_pkg::REG_STEP, 24'hFFFFF);
    write_reg(fsft_pkg::REG_SCALE, 24'd0);
    send_item(fsft_pkg::FUNC_FRAME, 24'd1234);
    write_reg(8'd9, 24'h123456);
    for (int p = 0; p < 6; p++) begin
      write_reg(fsft_pkg::REG_STEP, $urandom_range(0, 2) == 0 ?
                24'($urandom) : 24'($urandom_range(1, 40000)));
      write_reg(fsft_pkg::REG_MAXD, $urandom_range(0, 2) == 0 ?
                24'($urandom) : 24'($urandom_range(1, 300000)));
      write_reg(fsft_pkg::REG_SCALE, $urandom_range(0, 2) == 0 ?
                24'($urandom) : 24'($urandom_range(0, 1024)));
      write_reg(fsft_pkg::REG_PAUSED, (p == 3) ? 24'd1 : 24'd0);
      if (p == 5) quiet = 1;
      repeat (80) random_item();
    end
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("fixed_timestep_frame_timer_test: PASS");
    end else begin
      $display("fixed_timestep_frame_timer_test: FAIL");
    end
    $finish;
  end
endmodule

>>> files.f
sv/fsft_pkg.sv
sv/fsft_div.sv
sv/fsft_ctrl.sv
sv/fsft_dpath.sv
sv/fixed_timestep_frame_timer.sv
test/fixed_timestep_frame_timer_test.sv
